>>> design/asq_pkg.sv
// ----------------------------------------------------------------------------
// asq_pkg: shared types and constants for the ADC scan sequencer
// Slot table geometry, sample scaling constants, request and result formats.
// ----------------------------------------------------------------------------
`default_nettype none

package asq_pkg;

  localparam int SLOTS         = 8;
  localparam int SAMPLE_BITS   = 12;
  localparam int MV_W          = 12;
  localparam int FULL_SCALE_MV = 3300;
  localparam int MAX_CODE      = (1 << SAMPLE_BITS) - 1;
  localparam int PROD_W        = SAMPLE_BITS + MV_W;

  localparam int SLOT_W  = 3;
  localparam int CHAN_W  = 5;
  localparam int CNT_W   = 4;
  localparam int MASK_W  = 8;
  localparam int MAP_W   = 40;

  // request operations
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EOC  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_ENABLE_MASK = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_MAP = 2'd2;

  typedef struct packed {
    logic [1:0]             operation;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SLOT_W-1:0]      read_slot;
  } in_item_t;

  typedef struct packed {
    logic              start_valid;
    logic [CHAN_W-1:0] start_channel;
    logic [SLOT_W-1:0] start_slot;
    logic              store_valid;
    logic [SLOT_W-1:0] store_slot;
    logic [MV_W-1:0]   value_mv;
    logic              pass_running;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/adc_scan_sequencer_mv_core.sv
// ----------------------------------------------------------------------------
// adc_scan_sequencer_mv_core: ADC regular channel scan sequencer
// Tick, end-of-conversion and read requests; one result per request.
// ----------------------------------------------------------------------------
// Path to out_valid: read and ignored requests go straight to the output stage;
//   a tick runs search steps first; end of conversion runs MUL and DIV, then
//   search steps while a pass runs. A step checks one slot or the end.
// Throughput: one request at a time; the next can be taken while out_valid is high.
// Reset (rst_n low, synchronous): control and configuration registers, pass state
//   and all stored millivolt values clear to zero.
`default_nettype none

module adc_scan_sequencer_mv_core
  import asq_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  // request channel
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_data,
  // result channel
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data,
  // configuration writes
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [MAP_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;  // one slot per cycle
  localparam logic [2:0] ST_MUL    = 3'd2;  // scaler product register load
  localparam logic [2:0] ST_DIV    = 3'd3;  // divide-by-MAX_CODE correction, store
  localparam logic [2:0] ST_FIN    = 3'd4;  // hand result to output register

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       slot_count_r;
  logic [MASK_W-1:0]      enable_mask_r;
  logic [MAP_W-1:0]       channel_map_r;

  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]      cur_slot_r, cur_slot_nxt;
  logic                   in_pass_r, in_pass_nxt;
  logic                   conv_r, conv_nxt;
  logic                   out_valid_r, out_valid_nxt;

  in_item_t               req_r;
  out_item_t              res_r, res_nxt;
  out_item_t              out_data_r;
  logic [MV_W-1:0]        last_mv_r [SLOTS];

  logic                   accept;
  logic                   out_free;
  logic [CNT_W-1:0]       active_n;
  logic                   slot_en;
  logic [CHAN_W-1:0]      slot_chan;
  logic [MV_W-1:0]        mv;
  logic                   mv_we;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slot count clamps at the table size
  assign active_n  = (slot_count_r > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_r;
  assign slot_en   = enable_mask_r[scan_idx_r[SLOT_W-1:0]];
  assign slot_chan = channel_map_r[CHAN_W*scan_idx_r[SLOT_W-1:0] +: CHAN_W];

  asq_mv_scale u_scale (
    .clk    (clk),
    .load   (state_r == ST_MUL),
    .sample (req_r.sample),
    .mv     (mv)
  );

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    cur_slot_nxt  = cur_slot_r;
    in_pass_nxt   = in_pass_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    mv_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
          case (in_data.operation)
            OP_TICK: begin
              // busy tick is dropped with an empty result
              if (!in_pass_r && !conv_r) begin
                scan_idx_nxt = '0;
                state_nxt    = ST_SEARCH;
              end
            end
            OP_EOC: begin
              state_nxt = ST_MUL;
            end
            OP_READ: begin
              if (32'(in_data.read_slot) < SLOTS) begin
                res_nxt.value_mv = last_mv_r[in_data.read_slot];
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_MUL: begin
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        // stray completion still stores for the current slot
        mv_we               = 1'b1;
        res_nxt.store_valid = 1'b1;
        res_nxt.store_slot  = cur_slot_r;
        res_nxt.value_mv    = mv;
        conv_nxt            = 1'b0;
        if (in_pass_r) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          state_nxt    = ST_SEARCH;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_SEARCH: begin
        if (scan_idx_r < active_n) begin
          if (slot_en) begin
            cur_slot_nxt          = scan_idx_r[SLOT_W-1:0];
            conv_nxt              = 1'b1;
            in_pass_nxt           = 1'b1;
            res_nxt.start_valid   = 1'b1;
            res_nxt.start_channel = slot_chan;
            res_nxt.start_slot    = scan_idx_r[SLOT_W-1:0];
            state_nxt             = ST_FIN;
          end else begin
            scan_idx_nxt = scan_idx_r + CNT_W'(1);
          end
        end else begin
          // nothing left: pass ends (or a tick never starts one)
          in_pass_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      scan_idx_r    <= '0;
      cur_slot_r    <= '0;
      in_pass_r     <= 1'b0;
      conv_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      slot_count_r  <= '0;
      enable_mask_r <= '0;
      channel_map_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        last_mv_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cur_slot_r  <= cur_slot_nxt;
      in_pass_r   <= in_pass_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
      if (mv_we && (32'(cur_slot_r) < SLOTS)) begin
        last_mv_r[cur_slot_r] <= mv;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOT_COUNT:  slot_count_r  <= cfg_data[CNT_W-1:0];
          CFG_ENABLE_MASK: enable_mask_r <= cfg_data[MASK_W-1:0];
          CFG_CHANNEL_MAP: channel_map_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    res_r <= res_nxt;
    if (state_r == ST_FIN && out_free) begin
      // pass flag (lowest field) shows the state after the request
      out_data_r <= {res_r[$bits(out_item_t)-1:1], in_pass_r};
    end
  end

  // a conversion is only ever commanded inside a pass
  a_conv_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    conv_r |-> in_pass_r)
    else $error("conversion running outside a pass");

  a_start_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.start_valid) |-> out_data_r.pass_running)
    else $error("start commanded without a running pass");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (scan_idx_r <= CNT_W'(SLOTS)))
    else $error("scan index ran past the slot table");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (mv <= MV_W'(FULL_SCALE_MV)))
    else $error("scaled value above full scale");

endmodule

`default_nettype wire

>>> design/asq_mv_scale.sv
// ----------------------------------------------------------------------------
// asq_mv_scale: raw sample to millivolt scaler
// Registers sample*FULL_SCALE_MV, then divides by MAX_CODE with one
// shift-add and a single compare/increment correction.
// ----------------------------------------------------------------------------
`default_nettype none

module asq_mv_scale
  import asq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [MV_W-1:0]        mv
);

  logic [PROD_W-1:0]        prod_r;
  logic [MV_W-1:0]          quo0;
  logic [SAMPLE_BITS:0]     rem;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(sample) * PROD_W'(FULL_SCALE_MV);
    end
  end

  // x = q0*2^N + lo = q0*(2^N-1) + (q0+lo); remainder stays below 2*MAX_CODE
  always_comb begin
    quo0 = prod_r[PROD_W-1 -: MV_W];
    rem  = {1'b0, prod_r[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(quo0);
    if (rem >= (SAMPLE_BITS+1)'(MAX_CODE)) begin
      mv = quo0 + MV_W'(1);
    end else begin
      mv = quo0;
    end
  end

endmodule

`default_nettype wire
